[rtl/fcgs_pkg.sv]
// ----------------------------------------------------------------------------
// fcgs_pkg
// shared types and codes of the feed, cut and glue sequencer
// ----------------------------------------------------------------------------
package fcgs_pkg;

	// command codes on the input stream
	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_START_UP   = 3'd1;
	localparam logic [2:0] CMD_FEED_WAIT  = 3'd2;
	localparam logic [2:0] CMD_GRIP_READY = 3'd3;
	localparam logic [2:0] CMD_GRIP_OK    = 3'd4;
	localparam logic [2:0] CMD_CUT_NOW    = 3'd5;
	localparam logic [2:0] CMD_GLUE_NOW   = 3'd6;

	// classified request kind
	typedef enum logic [2:0] {
		KIND_TICK       = 3'd0,
		KIND_START_UP   = 3'd1,
		KIND_FEED_WAIT  = 3'd2,
		KIND_GRIP_READY = 3'd3,
		KIND_GRIP_OK    = 3'd4,
		KIND_CUT_NOW    = 3'd5,
		KIND_GLUE_NOW   = 3'd6,
		KIND_NOP        = 3'd7
	} kind_t;

	// request as held in the front stage and the queue
	typedef struct packed {
		kind_t       kind;
		logic [31:0] now_ms;
		logic        feeder_busy;
		logic        cutter_busy;
		logic        pump_busy;
		logic [15:0] operand;   // feed length or glue volume, by kind
	} item_t;

endpackage

[rtl/feed_cut_glue_sequencer.sv]
// ----------------------------------------------------------------------------
// feed_cut_glue_sequencer
// sequencer for a feed, cut and glue machine, one result per request
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   command, now_ms, feeder/cutter/pump busy, feed_length, glue_volume
//  m_axis    out  action, move_amount, dose_amount, busy_res, error
//  cfg       in   timeout_ms (0), startup_feed (1), glue_dose (2)
//
//  one request per cycle sustained unless m_axis stalls and the queue fills
//  path: front register, queue, then the state update into the result register
//  the queue lets the front keep taking requests while a result waits on m_axis
//  reset is asynchronous and needs no clearing pass
// ----------------------------------------------------------------------------
module feed_cut_glue_sequencer
	import fcgs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[2:0], now_ms[34:3], feeder_busy[35], cutter_busy[36],
	// pump_busy[37], feed_length[53:38], glue_volume[69:54], zero pad
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// action[2:0], move_amount[18:3], dose_amount[34:19], busy_res[35],
	// error[36], zero pad
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic  push;
	item_t push_item;
	logic  queue_full;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	fcgs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push          (push),
		.push_item     (push_item),
		.queue_full    (queue_full)
	);

	fcgs_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	fcgs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

[rtl/fcgs_front.sv]
// ----------------------------------------------------------------------------
// fcgs_front
// input stage: takes requests and classifies the command
// ----------------------------------------------------------------------------
module fcgs_front
	import fcgs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[2:0], now_ms[34:3], feeder_busy[35], cutter_busy[36],
	// pump_busy[37], feed_length[53:38], glue_volume[69:54], zero pad
	input  logic [71:0] s_axis_tdata,
	output logic        push,
	output item_t       push_item,
	input  logic        queue_full
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_in;

	always_comb begin
		item_in.now_ms      = s_axis_tdata[34:3];
		item_in.feeder_busy = s_axis_tdata[35];
		item_in.cutter_busy = s_axis_tdata[36];
		item_in.pump_busy   = s_axis_tdata[37];
		item_in.operand     = s_axis_tdata[53:38];
		unique case (s_axis_tdata[2:0])
			CMD_TICK:       item_in.kind = KIND_TICK;
			CMD_START_UP:   item_in.kind = KIND_START_UP;
			CMD_FEED_WAIT:  item_in.kind = KIND_FEED_WAIT;
			CMD_GRIP_READY: item_in.kind = KIND_GRIP_READY;
			CMD_GRIP_OK:    item_in.kind = KIND_GRIP_OK;
			CMD_CUT_NOW:    item_in.kind = KIND_CUT_NOW;
			CMD_GLUE_NOW: begin
				item_in.kind    = KIND_GLUE_NOW;
				item_in.operand = s_axis_tdata[69:54];
			end
			default:        item_in.kind = KIND_NOP;
		endcase
	end

	assign push          = valid_s1 && !queue_full;
	assign s_axis_tready = !valid_s1 || !queue_full;
	assign push_item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

endmodule

[rtl/fcgs_queue.sv]
// ----------------------------------------------------------------------------
// fcgs_queue
// short request queue between the front and back
// ----------------------------------------------------------------------------
module fcgs_queue
	import fcgs_pkg::*;
#(
	parameter int Depth = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	item_t            entry_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a request");

endmodule

[rtl/fcgs_back.sv]
// ----------------------------------------------------------------------------
// fcgs_back
// sequencer state, timeout check and result register
// ----------------------------------------------------------------------------
module fcgs_back
	import fcgs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        head_valid,
	input  item_t       head_item,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// action[2:0], move_amount[18:3], dose_amount[34:19], busy_res[35],
	// error[36], zero pad
	output logic [39:0] m_axis_tdata
);

	localparam logic [1:0] REG_TIMEOUT      = 2'd0;
	localparam logic [1:0] REG_STARTUP_FEED = 2'd1;
	localparam logic [1:0] REG_GLUE_DOSE    = 2'd2;

	typedef enum logic [3:0] {
		OP_IDLE    = 4'b0001,
		OP_STARTUP = 4'b0010,
		OP_FWC     = 4'b0100,
		OP_ERROR   = 4'b1000
	} op_t;

	typedef enum logic [8:0] {
		PH_START     = 9'b000000001,
		PH_HOME      = 9'b000000010,
		PH_FEED      = 9'b000000100,
		PH_CUT       = 9'b000001000,
		PH_WAIT_POS  = 9'b000010000,
		PH_FEED_MM   = 9'b000100000,
		PH_WAIT_GRIP = 9'b001000000,
		PH_CUT2      = 9'b010000000,
		PH_GLUE      = 9'b100000000
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_HOME  = 3'd1,
		ACT_MOVE  = 3'd2,
		ACT_CUT   = 3'd3,
		ACT_DROP  = 3'd4,
		ACT_ESTOP = 3'd5
	} act_t;

	logic [31:0] timeout_q;
	logic [15:0] startup_feed_q;
	logic [15:0] glue_dose_q;

	op_t         op_q, op_n;
	phase_t      ph_q, ph_n;
	logic [15:0] len_q, len_n;
	logic [31:0] pst_q, pst_n;
	logic        stop_q, stop_n;

	act_t        act_q, act_n;
	logic [15:0] mv_q, mv_n;
	logic [15:0] dose_q, dose_n;
	logic        busy_q, error_q;
	logic        out_valid_q;

	logic        running;
	logic [31:0] elapsed;
	logic        timed_out;

	assign pop           = head_valid && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, error_q, busy_q, dose_q, mv_q, act_q};

	assign running   = (op_q == OP_STARTUP) || (op_q == OP_FWC);
	assign elapsed   = head_item.now_ms - pst_q;
	// no timeout in the start phase, the phase timer is stale there
	assign timed_out = (op_q != OP_IDLE) && (ph_q != PH_START) && (elapsed > timeout_q);

	always_comb begin
		op_n   = op_q;
		ph_n   = ph_q;
		len_n  = len_q;
		pst_n  = pst_q;
		stop_n = stop_q;
		act_n  = ACT_NONE;
		mv_n   = '0;
		dose_n = '0;
		unique case (head_item.kind)
			KIND_TICK: begin
				if (timed_out || op_q == OP_ERROR) begin
					op_n = OP_ERROR;
					if (!stop_q) begin
						act_n  = ACT_ESTOP;
						stop_n = 1'b1;
					end
				end else if (op_q == OP_STARTUP) begin
					if (ph_q == PH_START) begin
						act_n = ACT_HOME;
						ph_n  = PH_HOME;
						pst_n = head_item.now_ms;
					end else if (ph_q == PH_HOME) begin
						if (!head_item.feeder_busy) begin
							act_n = ACT_MOVE;
							mv_n  = startup_feed_q;
							ph_n  = PH_FEED;
							pst_n = head_item.now_ms;
						end
					end else if (ph_q == PH_FEED) begin
						if (!head_item.feeder_busy) begin
							act_n = ACT_CUT;
							ph_n  = PH_CUT;
							pst_n = head_item.now_ms;
						end
					end else if (ph_q == PH_CUT) begin
						if (!head_item.cutter_busy) op_n = OP_IDLE;
					end
				end else if (op_q == OP_FWC) begin
					if (ph_q == PH_START) begin
						ph_n  = PH_WAIT_POS;
						pst_n = head_item.now_ms;
					end else if (ph_q == PH_FEED_MM) begin
						act_n = ACT_MOVE;
						mv_n  = len_q;
						ph_n  = PH_WAIT_GRIP;
						pst_n = head_item.now_ms;
					end else if (ph_q == PH_CUT2) begin
						act_n = ACT_CUT;
						ph_n  = PH_CUT;
						pst_n = head_item.now_ms;
					end else if (ph_q == PH_CUT) begin
						if (!head_item.cutter_busy) begin
							act_n  = ACT_DROP;
							dose_n = glue_dose_q;
							ph_n   = PH_GLUE;
							pst_n  = head_item.now_ms;
						end
					end else if (ph_q == PH_GLUE) begin
						if (!head_item.pump_busy) op_n = OP_IDLE;
					end
				end
			end
			KIND_START_UP: begin
				if (!running) begin
					op_n   = OP_STARTUP;
					ph_n   = PH_START;
					stop_n = 1'b0;
				end
			end
			KIND_FEED_WAIT: begin
				// length is taken even when the request is ignored
				len_n = head_item.operand;
				if (!running) begin
					op_n   = OP_FWC;
					ph_n   = PH_START;
					stop_n = 1'b0;
				end
			end
			KIND_GRIP_READY: begin
				if (op_q == OP_FWC && ph_q == PH_WAIT_POS) ph_n = PH_FEED_MM;
			end
			KIND_GRIP_OK: begin
				if (op_q == OP_FWC && ph_q == PH_WAIT_GRIP) ph_n = PH_CUT2;
			end
			KIND_CUT_NOW: begin
				if (!running) begin
					act_n = ACT_CUT;
					op_n  = OP_IDLE;
				end
			end
			KIND_GLUE_NOW: begin
				if (!running) begin
					act_n  = ACT_DROP;
					dose_n = head_item.operand;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q      <= 32'd8000;
			startup_feed_q <= 16'd200;
			glue_dose_q    <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT:      timeout_q      <= cfg_data;
				REG_STARTUP_FEED: startup_feed_q <= cfg_data[15:0];
				REG_GLUE_DOSE:    glue_dose_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_IDLE;
			ph_q        <= PH_START;
			len_q       <= '0;
			pst_q       <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				op_q   <= op_n;
				ph_q   <= ph_n;
				len_q  <= len_n;
				pst_q  <= pst_n;
				stop_q <= stop_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			act_q   <= act_n;
			mv_q    <= mv_n;
			dose_q  <= dose_n;
			busy_q  <= (op_n == OP_STARTUP) || (op_n == OP_FWC);
			error_q <= (op_n == OP_ERROR);
		end
	end

	a_estop_once: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (act_q != ACT_ESTOP) || stop_q)
		else $error("stop issued without being recorded");

	a_busy_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(busy_q && error_q))
		else $error("result is busy and in error at once");

	a_move_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && act_q != ACT_MOVE) |-> (mv_q == '0))
		else $error("move distance on a result that is not a move");

	a_error_state: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && op_q == OP_ERROR && head_item.kind == KIND_TICK) |=> (op_q == OP_ERROR))
		else $error("tick left the error state");

endmodule
